### rtl/core/hsvb_pkg.sv
// Package for the HSV histogram / Bhattacharyya block.
// Bin geometry, sequencer state types, config register codes and bin picking.
// No dependencies.
`default_nettype none
package hsvb_pkg;

    localparam int HUE_BINS   = 10;
    localparam int SAT_BINS   = 10;
    localparam int VAL_BINS   = 10;
    localparam int TOTAL_BINS = HUE_BINS * SAT_BINS + VAL_BINS;
    localparam int BIN_W      = $clog2(TOTAL_BINS);
    localparam int CNT_W      = 17;
    localparam int REF_W      = 16;
    localparam int MAX_PIXELS = 65536;
    localparam int HUE_SPAN   = 360;
    localparam int UNIT_SPAN  = 255;
    localparam int SUM_W      = 24;
    localparam int DIST_W     = 17;
    localparam int PROD_W     = CNT_W + REF_W;
    localparam int ROOT_W     = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_THR = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_FIN_START,
        ST_BIN_RD,
        ST_BIN_MUL,
        ST_UNIT_GO,
        ST_UNIT_WAIT,
        ST_EMIT
    } hsvb_state_t;

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_SQRT
    } hsvb_uphase_t;

    // floor(hue * HUE_BINS / 360), clamped to the top bin
    function automatic logic [4:0] hsvb_hue_idx(input logic [8:0] hue);
        logic [4:0] idx;
        idx = '0;
        for (int k = 1; k < HUE_BINS; k++)
        begin
            if (14'(hue) * 14'(HUE_BINS) >= 14'(HUE_SPAN * k))
                idx = idx + 5'd1;
        end
        return idx;
    endfunction

    // floor(x * nbins / 255), clamped to nbins-1
    function automatic logic [4:0] hsvb_unit_idx(input logic [7:0] x, input int nbins);
        logic [4:0] idx;
        idx = '0;
        for (int k = 1; k < 32; k++)
        begin
            if (k < nbins && 14'(x) * 14'(nbins) >= 14'(UNIT_SPAN * k))
                idx = idx + 5'd1;
        end
        return idx;
    endfunction

    function automatic logic [BIN_W-1:0] hsvb_pick(
        input logic [8:0] hue,
        input logic [7:0] sat,
        input logic [7:0] bri,
        input logic [7:0] sat_thr,
        input logic [7:0] val_thr
    );
        logic [4:0] hd;
        logic [4:0] sd;
        logic [4:0] vd;
        hd = hsvb_hue_idx(hue);
        sd = hsvb_unit_idx(sat, SAT_BINS);
        vd = hsvb_unit_idx(bri, VAL_BINS);
        if (sat < sat_thr || bri < val_thr)
            return BIN_W'(HUE_BINS * SAT_BINS) + BIN_W'(vd);
        return BIN_W'(BIN_W'(sd) * BIN_W'(HUE_BINS)) + BIN_W'(hd);
    endfunction

endpackage
`default_nettype wire

### rtl/core/hsvb_if.sv
// Valid/ready channel interfaces for pixel/reference beats and result beats.
// Depends on nothing.
`default_nettype none
interface hsvb_pix_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic [6:0] ref_index;
    logic [15:0] ref_fraction;
    logic       last_pixel;
    modport source (output valid, kind, hue, saturation, brightness, ref_index,
                    ref_fraction, last_pixel, input ready);
    modport sink   (input valid, kind, hue, saturation, brightness, ref_index,
                    ref_fraction, last_pixel, output ready);
endinterface

interface hsvb_res_if;
    logic        valid;
    logic        ready;
    logic [16:0] distance;
    logic        empty_region;
    modport source (output valid, distance, empty_region, input ready);
    modport sink   (input valid, distance, empty_region, output ready);
endinterface
`default_nettype wire

### rtl/core/hsvb_divsqrt.sv
// Shared iterative unit: floor((num << 16) / den) by restoring division,
// then floor square root of the quotient, one bit per cycle. Uses hsvb_pkg.
`default_nettype none
module hsvb_divsqrt
    import hsvb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] num,
    input  wire logic [CNT_W-1:0]  den,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);
    localparam int DVD_W = PROD_W + 16;

    hsvb_uphase_t      phase_reg, phase_next;
    logic [5:0]        step_reg, step_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [31:0]       quo_reg, quo_next;
    logic [CNT_W:0]    srem_reg, srem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic              done_reg, done_next;

    logic [CNT_W:0] dt;
    logic           dge;
    logic [CNT_W+1:0] st;
    logic [CNT_W+1:0] trial;
    logic           sge;

    always_comb
    begin
        dt    = {rem_reg[CNT_W-1:0], dvd_reg[DVD_W-1]};
        dge   = dt >= {1'b0, den};
        st    = {srem_reg[CNT_W-1:0], quo_reg[31:30]};
        trial = {1'b0, root_reg, 2'b01};
        sge   = st >= trial;

        phase_next = phase_reg;
        step_next  = step_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        done_next  = 1'b0;

        unique case (phase_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    phase_next = U_DIV;
                    step_next  = 6'(DVD_W - 1);
                    dvd_next   = {num, 16'd0};
                    rem_next   = '0;
                    quo_next   = '0;
                end
            end
            U_DIV:
            begin
                rem_next = dge ? (dt - {1'b0, den}) : dt;
                quo_next = {quo_reg[30:0], dge};
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                step_next = step_reg - 6'd1;
                if (step_reg == 6'd0)
                begin
                    phase_next = U_SQRT;
                    step_next  = 6'(ROOT_W - 1);
                    srem_next  = '0;
                    root_next  = '0;
                end
            end
            U_SQRT:
            begin
                srem_next = sge ? (CNT_W+1)'(st - trial) : (CNT_W+1)'(st);
                root_next = {root_reg[ROOT_W-2:0], sge};
                quo_next  = {quo_reg[29:0], 2'b00};
                step_next = step_reg - 6'd1;
                if (step_reg == 6'd0)
                begin
                    phase_next = U_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
                phase_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

### rtl/core/hsv_histogram_bhattacharyya.sv
// HSV histogram accumulation against a stored reference, Bhattacharyya distance.
// Reference beats are taken back to back; a pixel beat holds off the next until
// its bin is read and written back. A closing beat adds a walk of 110 bins (4
// sequencer steps + 49-step divide + 16-step root); not ready until emitted.
// Reset: counts and pixel count cleared, thresholds set to 26 and 51; reference bins
// hold nothing until loaded. Depends on hsvb_pkg, hsvb_if, hsvb_divsqrt.
`default_nettype none
module hsv_histogram_bhattacharyya
    import hsvb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    hsvb_pix_if.sink                  pix,
    hsvb_res_if.source                res,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_wdata
);
    hsvb_state_t state_reg, state_next;

    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  pix_cnt_reg, pix_cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next;
    logic              out_empty_reg, out_empty_next;
    logic [7:0]        sth_reg, vth_reg;
    logic [TOTAL_BINS-1:0] cnt_vld_reg, cnt_vld_next;

    // bin memories: counts use per-entry valid bits, reference has no reset
    logic [CNT_W-1:0] count_mem [TOTAL_BINS];
    logic [REF_W-1:0] ref_mem   [TOTAL_BINS];
    logic [CNT_W-1:0] cnt_rd_reg;
    logic [REF_W-1:0] ref_rd_reg;

    logic             pix_acc;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] cnt_inc;
    logic             cnt_we;
    logic             unit_start;
    logic             unit_done;
    logic [ROOT_W-1:0] unit_root;

    assign pix.ready = (state_reg == ST_IDLE);
    assign pix_acc   = pix.valid && pix.ready;
    assign cnt_eff   = cnt_vld_reg[bin_reg] ? cnt_rd_reg : '0;
    assign cnt_inc   = cnt_eff + CNT_W'(1);
    assign cnt_we    = (state_reg == ST_PIX_WR);
    assign unit_start = (state_reg == ST_UNIT_GO);

    hsvb_divsqrt u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .num   (prod_reg),
        .den   (pix_cnt_reg),
        .done  (unit_done),
        .root  (unit_root)
    );

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        last_next      = last_reg;
        pix_cnt_next   = pix_cnt_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_dist_next  = out_dist_reg;
        out_empty_next = out_empty_reg;
        cnt_vld_next   = cnt_vld_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_acc)
                begin
                    last_next = pix.last_pixel;
                    if (!pix.kind && pix_cnt_reg < CNT_W'(MAX_PIXELS))
                    begin
                        bin_next   = hsvb_pick(pix.hue, pix.saturation, pix.brightness,
                                               sth_reg, vth_reg);
                        state_next = ST_PIX_RD;
                    end
                    else if (pix.last_pixel)
                        state_next = ST_FIN_START;
                end
            end
            ST_PIX_RD:
                state_next = ST_PIX_WR;
            ST_PIX_WR:
            begin
                cnt_vld_next[bin_reg] = 1'b1;
                pix_cnt_next = pix_cnt_reg + CNT_W'(1);
                state_next   = last_reg ? ST_FIN_START : ST_IDLE;
            end
            ST_FIN_START:
            begin
                bin_next = '0;
                sum_next = '0;
                state_next = (pix_cnt_reg == '0) ? ST_EMIT : ST_BIN_RD;
            end
            ST_BIN_RD:
                state_next = ST_BIN_MUL;
            ST_BIN_MUL:
            begin
                prod_next  = PROD_W'(cnt_eff) * PROD_W'(ref_rd_reg);
                state_next = ST_UNIT_GO;
            end
            ST_UNIT_GO:
                state_next = ST_UNIT_WAIT;
            ST_UNIT_WAIT:
            begin
                if (unit_done)
                begin
                    sum_next = sum_reg + SUM_W'(unit_root);
                    if (bin_reg == BIN_W'(TOTAL_BINS - 1))
                        state_next = ST_EMIT;
                    else
                    begin
                        bin_next   = bin_reg + BIN_W'(1);
                        state_next = ST_BIN_RD;
                    end
                end
            end
            ST_EMIT:
            begin
                // wait for the output register to drain before loading it
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_empty_next = (pix_cnt_reg == '0);
                    if (pix_cnt_reg == '0 || sum_reg >= SUM_W'(65536))
                        out_dist_next = '0;
                    else
                        out_dist_next = DIST_W'(SUM_W'(65536) - sum_reg);
                    cnt_vld_next = '0;
                    pix_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pix_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            cnt_vld_reg   <= '0;
            sth_reg       <= 8'd26;
            vth_reg       <= 8'd51;
        end
        else
        begin
            state_reg     <= state_next;
            pix_cnt_reg   <= pix_cnt_next;
            out_valid_reg <= out_valid_next;
            cnt_vld_reg   <= cnt_vld_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_SAT_THR)
                    sth_reg <= cfg_wdata;
                else if (cfg_index == CFG_VAL_THR)
                    vth_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg       <= bin_next;
        last_reg      <= last_next;
        sum_reg       <= sum_next;
        prod_reg      <= prod_next;
        out_dist_reg  <= out_dist_next;
        out_empty_reg <= out_empty_next;
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            count_mem[bin_reg] <= cnt_inc;
        cnt_rd_reg <= count_mem[bin_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc && pix.kind && pix.ref_index < BIN_W'(TOTAL_BINS))
            ref_mem[pix.ref_index] <= pix.ref_fraction;
        ref_rd_reg <= ref_mem[bin_reg];
    end

    assign res.valid        = out_valid_reg;
    assign res.distance     = out_dist_reg;
    assign res.empty_region = out_empty_reg;

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.empty_region |-> res.distance == '0)
        else $error("empty region with nonzero distance");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pix_cnt_reg <= CNT_W'(MAX_PIXELS))
        else $error("pixel count above limit");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && state_next == ST_IDLE |=>
            pix_cnt_reg == '0 && cnt_vld_reg == '0 && out_valid_reg)
        else $error("result emitted without clearing histogram");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.distance <= DIST_W'(65536))
        else $error("distance out of range");

endmodule
`default_nettype wire

### verif/tb_hsv_histogram_bhattacharyya.sv
// Self-checking testbench for hsv_histogram_bhattacharyya: histogram binning,
// reference loads, distance results and threshold registers.
// Depends on hsvb_pkg, hsvb_if and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_hsv_histogram_bhattacharyya;
    import hsvb_pkg::*;

    // beat kinds on the pixel channel
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_REF   = 1'b1;
    // register indexes past the end of the list; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    // cycles with no beat accepted on either channel before giving up;
    // set to outlast a closing walk plus the long receiver hold-off
    localparam int STALL_LIMIT  = 60000;
    localparam int HOLD_CYCLES  = 20000;  // long enough for the block to fill behind a held result
    localparam int DRAIN_CYCLES = 12;   // covers the pixel read and write-back states

    typedef struct packed {
        logic        kind;
        logic [8:0]  hue;
        logic [7:0]  sat;
        logic [7:0]  bri;
        logic [6:0]  ridx;
        logic [15:0] rfrac;
        logic        last;
    } pix_beat_t;

    typedef struct packed {
        logic [16:0] distance;
        logic        empty;
    } dist_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_wdata;

    hsvb_pix_if pix_ch ();
    hsvb_res_if res_ch ();

    hsv_histogram_bhattacharyya dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch.sink),
        .res       (res_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------
    // Predictor state: own copy of the histogram, reference and thresholds
    // ---------------------------------------------------------------
    int unsigned  hist_count [TOTAL_BINS];
    int unsigned  ref_weight [TOTAL_BINS];
    int unsigned  region_pixels;
    logic [7:0]   sat_thr;
    logic [7:0]   val_thr;
    dist_result_t dist_expected [$];

    int src_idle_pct;
    int snk_idle_pct;
    int hold_request;           // bumped by a test to start a hold-off
    int hold_seen    = 0;
    int hold_left    = 0;
    int error_count  = 0;
    int stall_cycles = 0;

    function automatic int unsigned scaled_idx(int unsigned x, int unsigned nbins,
                                               int unsigned span);
        int unsigned q;
        q = x * nbins / span;
        return (q > nbins - 1) ? nbins - 1 : q;
    endfunction

    function automatic int unsigned histogram_bin(pix_beat_t b);
        // colourless pixels go to brightness bins after the hue x sat grid
        if (b.sat < sat_thr || b.bri < val_thr)
            return HUE_BINS * SAT_BINS + scaled_idx(b.bri, VAL_BINS, UNIT_SPAN);
        return scaled_idx(b.sat, SAT_BINS, UNIT_SPAN) * HUE_BINS
               + scaled_idx(b.hue, HUE_BINS, HUE_SPAN);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int k = 31; k >= 0; k--)
        begin
            t = r | (64'd1 << k);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic dist_result_t region_distance();
        dist_result_t    r;
        longint unsigned prod;
        int unsigned     coeff;
        coeff = 0;
        if (region_pixels == 0)
        begin
            r.distance = '0;
            r.empty    = 1'b1;
            return r;
        end
        for (int i = 0; i < TOTAL_BINS; i++)
        begin
            prod  = (longint'(hist_count[i]) * ref_weight[i] << 16) / region_pixels;
            coeff += 32'(int_sqrt(prod));
        end
        r.distance = (coeff >= 65536) ? 17'd0 : 17'(65536 - coeff);
        r.empty    = 1'b0;
        return r;
    endfunction

    // update the predictor for one accepted beat
    task automatic predict_beat(input pix_beat_t b);
        int unsigned bin;
        if (b.kind == KIND_REF)
        begin
            if (b.ridx < TOTAL_BINS)
                ref_weight[b.ridx] = b.rfrac;
        end
        else if (region_pixels < MAX_PIXELS)
        begin
            bin = histogram_bin(b);
            hist_count[bin]++;
            region_pixels++;
        end
        if (b.last)
        begin
            dist_expected.push_back(region_distance());
            foreach (hist_count[i])
                hist_count[i] = 0;
            region_pixels = 0;
        end
    endtask

    // ---------------------------------------------------------------
    // Sender: one beat, with random idle cycles ahead of it
    // ---------------------------------------------------------------
    task automatic send_beat(input pix_beat_t b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid        <= 1'b1;
        pix_ch.kind         <= b.kind;
        pix_ch.hue          <= b.hue;
        pix_ch.saturation   <= b.sat;
        pix_ch.brightness   <= b.bri;
        pix_ch.ref_index    <= b.ridx;
        pix_ch.ref_fraction <= b.rfrac;
        pix_ch.last_pixel   <= b.last;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        predict_beat(b);
    endtask

    function automatic pix_beat_t pixel(int unsigned hue, int unsigned sat,
                                        int unsigned bri, logic last);
        pix_beat_t b;
        b       = pix_beat_t'($urandom());   // junk in the unused fields
        b.kind  = KIND_PIXEL;
        b.hue   = 9'(hue);
        b.sat   = 8'(sat);
        b.bri   = 8'(bri);
        b.last  = last;
        return b;
    endfunction

    function automatic pix_beat_t ref_load(int unsigned idx, int unsigned frac,
                                           logic last);
        pix_beat_t b;
        b       = pix_beat_t'($urandom());
        b.kind  = KIND_REF;
        b.ridx  = 7'(idx);
        b.rfrac = 16'(frac);
        b.last  = last;
        return b;
    endfunction

    function automatic pix_beat_t random_pixel(logic last);
        return pixel($urandom_range(0, 511), $urandom_range(0, 255),
                     $urandom_range(0, 255), last);
    endfunction

    // wait for every predicted result, then let the pipeline settle
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (dist_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SAT_THR)
            sat_thr = val;
        else if (idx == CFG_VAL_THR)
            val_thr = val;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Receiver and result check
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        dist_result_t want;
        if (hold_request != hold_seen)
        begin
            hold_seen    <= hold_request;
            hold_left    <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else
            res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (dist_expected.size() == 0)
            begin
                $display("%0t: unexpected result distance=%0d empty=%0b", $time,
                         res_ch.distance, res_ch.empty_region);
                error_count++;
            end
            else
            begin
                want = dist_expected.pop_front();
                if (res_ch.distance !== want.distance)
                begin
                    $display("%0t: distance expected %0d actual %0d", $time,
                             want.distance, res_ch.distance);
                    error_count++;
                end
                if (res_ch.empty_region !== want.empty)
                begin
                    $display("%0t: empty_region expected %0b actual %0b", $time,
                             want.empty, res_ch.empty_region);
                    error_count++;
                end
            end
        end
    end

    // watchdog: counts cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // every reference bin is loaded before any region closes, so the
    // distance walk never reads an unwritten entry
    task automatic test_reference_setup();
        for (int i = 0; i < TOTAL_BINS; i++)
            send_beat(ref_load(i, $urandom_range(0, 1200), 1'b0));
        drain();
    endtask

    task automatic test_directed();
        // empty region: closing mark on a reference load with no pixels
        send_beat(ref_load(5, 16'hFFFF, 1'b1));
        // out-of-range reference index ignored, also as a closing beat
        send_beat(ref_load(TOTAL_BINS, 16'h1234, 1'b0));
        send_beat(ref_load(127, 16'hFFFF, 1'b1));
        // field extremes, hue above 360 clamps to the top hue bin
        send_beat(pixel(0, 0, 0, 1'b0));
        send_beat(pixel(511, 255, 255, 1'b0));
        send_beat(pixel(361, 200, 200, 1'b0));
        send_beat(pixel(359, 255, 25, 1'b0));
        send_beat(pixel(360, 26, 51, 1'b1));
        // closing on a reference load after pixels
        send_beat(pixel(100, 128, 128, 1'b0));
        send_beat(ref_load(0, 16'h0000, 1'b1));
        drain();
        // single bin against a full reference gives distance near zero
        write_reg(CFG_SAT_THR, 8'd0);
        write_reg(CFG_VAL_THR, 8'd0);
        send_beat(ref_load(0, 16'hFFFF, 1'b0));
        send_beat(pixel(0, 0, 255, 1'b0));
        send_beat(pixel(0, 0, 255, 1'b1));
        // all-ones reference over many bins saturates the distance at zero
        for (int i = 0; i < TOTAL_BINS; i++)
            send_beat(ref_load(i, 16'hFFFF, 1'b0));
        for (int i = 0; i < 6; i++)
            send_beat(pixel(i * 60, i * 50, 255, i == 5));
        drain();
        // writes to indexes past the list leave the thresholds alone
        write_reg(CFG_SPARE_A, 8'd200);
        write_reg(CFG_SPARE_B, 8'd200);
        send_beat(pixel(30, 10, 10, 1'b1));
        drain();
        test_reference_setup();
    endtask

    // random regions: mostly well formed, with reference reloads,
    // stray out-of-range loads and the odd empty region mixed in
    task automatic test_random_regions(input int beats);
        int sent;
        int len;
        sent = 0;
        while (sent < beats)
        begin
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 50);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 19))
                    0: send_beat(ref_load($urandom_range(0, TOTAL_BINS - 1),
                                          $urandom(), 1'b0));
                    1: send_beat(ref_load($urandom_range(TOTAL_BINS, 127),
                                          $urandom(), 1'b0));
                    default: send_beat(random_pixel(1'b0));
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                send_beat(ref_load($urandom_range(0, 127), $urandom(), 1'b1));
            else
                send_beat(random_pixel(1'b1));
            sent += len + 1;
        end
        drain();
    endtask

    // receiver holds off while short regions keep coming, filling the block
    task automatic test_backpressure();
        hold_request = hold_request + 1;
        for (int i = 0; i < 12; i++)
        begin
            send_beat(random_pixel(1'b0));
            send_beat(random_pixel(1'b1));
        end
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        pix_ch.valid = 1'b0;
        pix_ch.kind  = KIND_PIXEL;
        pix_ch.hue   = '0;
        pix_ch.saturation   = '0;
        pix_ch.brightness   = '0;
        pix_ch.ref_index    = '0;
        pix_ch.ref_fraction = '0;
        pix_ch.last_pixel   = 1'b0;
        hold_request = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        foreach (hist_count[i])
        begin
            hist_count[i] = 0;
            ref_weight[i] = 0;
        end
        region_pixels = 0;
        sat_thr = 8'd26;
        val_thr = 8'd51;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reference_setup();
        test_directed();

        src_idle_pct = 34;
        snk_idle_pct = 73;
        write_reg(CFG_SAT_THR, 8'd26);
        write_reg(CFG_VAL_THR, 8'd51);
        test_random_regions(500);
        test_backpressure();

        src_idle_pct = 73;
        snk_idle_pct = 34;
        write_reg(CFG_SAT_THR, 8'd255);
        write_reg(CFG_VAL_THR, 8'd0);
        test_random_regions(350);
        write_reg(CFG_SAT_THR, 8'd0);
        write_reg(CFG_VAL_THR, 8'd255);
        test_random_regions(200);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(CFG_SAT_THR, 8'($urandom_range(1, 254)));
        write_reg(CFG_VAL_THR, 8'($urandom_range(1, 254)));
        test_random_regions(350);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

### hsv_histogram_bhattacharyya.f
rtl/core/hsvb_pkg.sv
rtl/core/hsvb_if.sv
rtl/core/hsvb_divsqrt.sv
rtl/core/hsv_histogram_bhattacharyya.sv
verif/tb_hsv_histogram_bhattacharyya.sv
